[rtl/rtbp_pkg.sv]
// Shared types and constants for the raster threshold bit packer.
package rtbp_pkg;

   // Widest row the printer takes, in pixels.
   localparam int MAX_ROW_DOTS = 576;

   localparam int GRAY_W   = 8;
   localparam int WIDTH_W  = 10;
   localparam int HEIGHT_W = 16;
   localparam int BPR_W    = WIDTH_W - 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DARK_THRESHOLD = 2'd2;

   localparam logic [WIDTH_W-1:0]  RESET_WIDTH     = 10'd384;
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT    = 16'd1;
   localparam logic [GRAY_W-1:0]   RESET_THRESHOLD = 8'd200;

   // Raster command header bytes: GS v 0 m.
   localparam logic [7:0] CMD_GS   = 8'h1D;
   localparam logic [7:0] CMD_V    = 8'h76;
   localparam logic [7:0] CMD_ZERO = 8'h30;
   localparam logic [7:0] CMD_MODE = 8'h00;

   // Output sequencer steps of one queued job.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_HDR_GS   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_HDR_V    = 4'd1;
   localparam logic [STEP_W-1:0] STEP_HDR_ZERO = 4'd2;
   localparam logic [STEP_W-1:0] STEP_HDR_MODE = 4'd3;
   localparam logic [STEP_W-1:0] STEP_HDR_XL   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_HDR_XH   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_HDR_YL   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_HDR_YH   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_DATA     = 4'd8;

   // Job queue between the pixel front end and the byte sequencer.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                 hdr;       // emit the eight header bytes first
      logic [BPR_W-1:0]     bpr;       // bytes per row for the header
      logic [HEIGHT_W-1:0]  rows;      // row count for the header
      logic                 data;      // a packed dot byte follows
      logic [7:0]           dots;
      logic                 last;      // dot byte closes the image
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[rtl/raster_threshold_bit_packer_core.sv]
// Top level of the raster threshold bit packer: front end, job queue, byte sequencer.
//
//   Port group  Direction  Handshake              Payload
//   req_        in         req_valid / req_ready   req_gray_level
//   rsp_        out        rsp_valid / rsp_ready   rsp_out_byte, rsp_is_last
//   csr_        in         csr_write_enable        csr_index, csr_write_data
//
// One pixel transaction is taken per cycle while the job queue is not full. A pixel
// that closes a byte or a row writes its job into the queue when it is accepted;
// the byte sequencer then loads the job's bytes into its output register, which
// drives rsp_valid. The first pixel of an image adds eight header bytes ahead of
// its data; the sequencer sends one byte per cycle while the receiver is ready,
// and the four-entry job queue takes up that burst, so req_ready drops only when
// the queue is full. Reset is synchronous and active high and clears all control
// state; the image restarts with a header.
module raster_threshold_bit_packer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [rtbp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rtbp_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rtbp_pkg::GRAY_W-1:0]       req_gray_level,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_is_last
);

   // Job handoff between the front end and the sequencer.
   logic                        q_push;
   logic                        q_pop;
   rtbp_pkg::job_type           q_in_job;
   rtbp_pkg::job_type           q_head_job;
   rtbp_pkg::queue_status_type  q_status;

   // The front end keeps the registers and the row and column counters, and
   // turns every pixel into at most one job: a header request, a dot byte, or both.
   rtbp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_gray_level   (req_gray_level),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_job            (q_in_job)
   );

   rtbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_in_job),
      .pop      (q_pop),
      .head_job (q_head_job),
      .status   (q_status)
   );

   // The sequencer walks the header bytes when a job asks for them, then the
   // dot byte, and retires the job with its final byte.
   rtbp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (q_head_job),
      .q_status     (q_status),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_last  (rsp_is_last)
   );

   // A job must never be written into a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("job pushed into a full queue");

   // The sequencer must never retire a job that is not there.
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_status.empty))
      else $error("job popped from an empty queue");

   // A full queue stays full until the sequencer retires a job.
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (q_status.full && !q_pop) |=> q_status.full)
      else $error("full queue lost an entry without a pop");

endmodule

[rtl/rtbp_front.sv]
// Pixel front end: configuration, thresholding, bit packing and job creation.
module rtbp_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [rtbp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rtbp_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [rtbp_pkg::GRAY_W-1:0]          req_gray_level,
   input  rtbp_pkg::queue_status_type           q_status,
   output logic                                 q_push,
   output rtbp_pkg::job_type                    q_job
);

   logic [rtbp_pkg::WIDTH_W-1:0]  width_ff,  width_in;
   logic [rtbp_pkg::HEIGHT_W-1:0] height_ff, height_in;
   logic [rtbp_pkg::GRAY_W-1:0]   thresh_ff, thresh_in;

   logic [rtbp_pkg::WIDTH_W-1:0]  col_ff, col_in;
   logic [rtbp_pkg::HEIGHT_W-1:0] row_ff, row_in;
   logic [7:0]                    acc_ff, acc_in;
   logic                          hdr_done_ff, hdr_done_in;

   logic [rtbp_pkg::WIDTH_W-1:0]  w_eff;
   logic [rtbp_pkg::HEIGHT_W-1:0] h_eff;
   logic [rtbp_pkg::WIDTH_W:0]    col_next;
   logic [rtbp_pkg::WIDTH_W:0]    bpr_sum;
   logic [rtbp_pkg::HEIGHT_W-1:0] row_next;
   logic [7:0]                    acc_new;
   logic                          accept;
   logic                          row_end;
   logic                          img_end;
   logic                          byte_end;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thresh_in = thresh_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rtbp_pkg::CSR_IMAGE_WIDTH:    width_in  = csr_write_data[rtbp_pkg::WIDTH_W-1:0];
            rtbp_pkg::CSR_IMAGE_HEIGHT:   height_in = csr_write_data[rtbp_pkg::HEIGHT_W-1:0];
            rtbp_pkg::CSR_DARK_THRESHOLD: thresh_in = csr_write_data[rtbp_pkg::GRAY_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the configured geometry.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = rtbp_pkg::WIDTH_W'(1);
      end else if ({2'b00, width_ff} > 12'(rtbp_pkg::MAX_ROW_DOTS)) begin
         w_eff = rtbp_pkg::WIDTH_W'(rtbp_pkg::MAX_ROW_DOTS);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff == '0) ? rtbp_pkg::HEIGHT_W'(1) : height_ff;
   end

   assign accept    = req_valid && req_ready;
   assign req_ready = !q_status.full;

   always_comb begin
      acc_new = acc_ff;
      if (req_gray_level < thresh_ff) begin
         acc_new = acc_ff | (8'h80 >> col_ff[2:0]);
      end
      col_next = {1'b0, col_ff} + 1'b1;
      row_end  = col_next >= {1'b0, w_eff};
      row_next = row_ff + 1'b1;
      img_end  = row_end && ((row_next >= h_eff) || (row_next == '0));
      byte_end = row_end || (col_next[2:0] == 3'd0);
      bpr_sum  = {1'b0, w_eff} + (rtbp_pkg::WIDTH_W+1)'(7);
   end

   always_comb begin
      q_job.hdr  = !hdr_done_ff;
      q_job.bpr  = bpr_sum[rtbp_pkg::WIDTH_W:3];
      q_job.rows = h_eff;
      q_job.data = byte_end;
      q_job.dots = acc_new;
      q_job.last = img_end;
      q_push     = accept && (!hdr_done_ff || byte_end);
   end

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      acc_in      = acc_ff;
      hdr_done_in = hdr_done_ff;
      if (accept) begin
         hdr_done_in = 1'b1;
         if (row_end) begin
            col_in = '0;
            acc_in = '0;
            if (img_end) begin
               row_in      = '0;
               hdr_done_in = 1'b0;
            end else begin
               row_in = row_next;
            end
         end else begin
            col_in = col_next[rtbp_pkg::WIDTH_W-1:0];
            acc_in = byte_end ? 8'h00 : acc_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= rtbp_pkg::RESET_WIDTH;
         height_ff   <= rtbp_pkg::RESET_HEIGHT;
         thresh_ff   <= rtbp_pkg::RESET_THRESHOLD;
         col_ff      <= '0;
         row_ff      <= '0;
         acc_ff      <= '0;
         hdr_done_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         thresh_ff   <= thresh_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         acc_ff      <= acc_in;
         hdr_done_ff <= hdr_done_in;
      end
   end

endmodule

[rtl/rtbp_queue.sv]
// Small job queue between the pixel front end and the byte sequencer.
module rtbp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  rtbp_pkg::job_type           push_job,
   input  logic                        pop,
   output rtbp_pkg::job_type           head_job,
   output rtbp_pkg::queue_status_type  status
);

   rtbp_pkg::job_type               entry_ff [rtbp_pkg::QUEUE_DEPTH];
   logic [rtbp_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [rtbp_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [rtbp_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;

   assign status.full  = cnt_ff == rtbp_pkg::QCNT_W'(rtbp_pkg::QUEUE_DEPTH);
   assign status.empty = cnt_ff == '0;
   assign head_job     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

[rtl/rtbp_back.sv]
// Byte sequencer: expands queued jobs into header and dot bytes.
module rtbp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  rtbp_pkg::job_type           head_job,
   input  rtbp_pkg::queue_status_type  q_status,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_is_last
);

   logic [rtbp_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        valid_ff, valid_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        last_ff, last_in;

   logic [rtbp_pkg::STEP_W-1:0] cur_step;
   logic [15:0]                 bpr_wide;
   logic                        advance;
   logic                        job_done;
   logic [7:0]                  sel_byte;

   assign bpr_wide = 16'(head_job.bpr);
   assign advance  = !q_status.empty && (!valid_ff || rsp_ready);
   assign cur_step = head_job.hdr ? step_ff : rtbp_pkg::STEP_DATA;
   assign job_done = (cur_step == rtbp_pkg::STEP_DATA) ||
                     ((cur_step == rtbp_pkg::STEP_HDR_YH) && !head_job.data);
   assign q_pop    = advance && job_done;

   always_comb begin
      unique case (cur_step)
         rtbp_pkg::STEP_HDR_GS:   sel_byte = rtbp_pkg::CMD_GS;
         rtbp_pkg::STEP_HDR_V:    sel_byte = rtbp_pkg::CMD_V;
         rtbp_pkg::STEP_HDR_ZERO: sel_byte = rtbp_pkg::CMD_ZERO;
         rtbp_pkg::STEP_HDR_MODE: sel_byte = rtbp_pkg::CMD_MODE;
         rtbp_pkg::STEP_HDR_XL:   sel_byte = bpr_wide[7:0];
         rtbp_pkg::STEP_HDR_XH:   sel_byte = bpr_wide[15:8];
         rtbp_pkg::STEP_HDR_YL:   sel_byte = head_job.rows[7:0];
         rtbp_pkg::STEP_HDR_YH:   sel_byte = head_job.rows[15:8];
         default:                 sel_byte = head_job.dots;
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff && !rsp_ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = 1'b1;
         byte_in  = sel_byte;
         last_in  = (cur_step == rtbp_pkg::STEP_DATA) && head_job.last;
         step_in  = job_done ? rtbp_pkg::STEP_HDR_GS : cur_step + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= rtbp_pkg::STEP_HDR_GS;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_is_last  = last_ff;

endmodule

[bench/testbench.sv]
// Self-checking testbench for the raster threshold bit packer core.
`timescale 1ns / 100ps

module testbench;

   // Unmapped register index; a write to it must change nothing.
   localparam logic [rtbp_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   // An accepted pixel's job passes through the job queue to the output register,
   // and the settle wait also covers a pixel that is still in flight without a byte.
   localparam int SETTLE_CYCLES       = 8;
   localparam int END_TAIL_CYCLES     = 16;
   localparam int LONG_HOLD_CYCLES    = 60;
   localparam int RANDOM_PIXEL_TARGET = 110;
   localparam int MAX_IMAGE_PIXELS    = 80;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_last;
   } printer_byte_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_write_enable = 1'b0;
   logic [rtbp_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [rtbp_pkg::CSR_DATA_W-1:0] csr_write_data = '0;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [rtbp_pkg::GRAY_W-1:0]     req_gray_level = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [7:0]                      rsp_out_byte;
   logic                            rsp_is_last;

   raster_threshold_bit_packer_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_gray_level   (req_gray_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_last      (rsp_is_last)
   );

   always #4 clock = ~clock;

   // Local copy of the configuration registers, updated at each write.
   logic [rtbp_pkg::WIDTH_W-1:0]  cfg_width     = rtbp_pkg::RESET_WIDTH;
   logic [rtbp_pkg::HEIGHT_W-1:0] cfg_height    = rtbp_pkg::RESET_HEIGHT;
   logic [rtbp_pkg::GRAY_W-1:0]   cfg_threshold = rtbp_pkg::RESET_THRESHOLD;

   // Rasterizer state: where the next pixel lands and the byte being built.
   int                            dot_column  = 0;
   logic [rtbp_pkg::HEIGHT_W-1:0] dot_row     = '0;
   logic [7:0]                    dot_byte    = '0;
   bit                            header_sent = 1'b0;

   logic [rtbp_pkg::GRAY_W-1:0] pixels_to_send[$];
   printer_byte_type            printer_bytes_due[$];
   printer_byte_type            oldest_due;

   int pixels_queued   = 0;
   int pixels_accepted = 0;
   int bytes_checked   = 0;
   int images_closed   = 0;
   int csr_writes      = 0;
   int error_count     = 0;
   int phase_no        = 0;

   // Idle rates in percent, set per phase by the stimulus process.
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // A toggle of hold_trigger asks the receiver for one long hold-off.
   bit hold_trigger = 1'b0;
   bit hold_seen    = 1'b0;
   int hold_left    = 0;

   // Width and height as the block uses them: out-of-range values are clamped.
   function automatic int row_pixels();
      if (cfg_width == 0) return 1;
      if (cfg_width > rtbp_pkg::MAX_ROW_DOTS) return rtbp_pkg::MAX_ROW_DOTS;
      return int'(cfg_width);
   endfunction

   function automatic int image_rows();
      return (cfg_height == 0) ? 1 : int'(cfg_height);
   endfunction

   // Works out the bytes that one accepted pixel causes and queues them.
   // The first pixel of an image brings the eight header bytes ahead of its data.
   function automatic void rasterize_pixel(input logic [rtbp_pkg::GRAY_W-1:0] gray);
      int   w;
      int   h;
      int   bpr;
      logic closes_image;
      w = row_pixels();
      h = image_rows();
      if (!header_sent) begin
         bpr = (w + 7) / 8;
         printer_bytes_due.push_back(printer_byte_type'{rtbp_pkg::CMD_GS, 1'b0});
         printer_bytes_due.push_back(printer_byte_type'{rtbp_pkg::CMD_V, 1'b0});
         printer_bytes_due.push_back(printer_byte_type'{rtbp_pkg::CMD_ZERO, 1'b0});
         printer_bytes_due.push_back(printer_byte_type'{rtbp_pkg::CMD_MODE, 1'b0});
         printer_bytes_due.push_back(printer_byte_type'{bpr[7:0], 1'b0});
         printer_bytes_due.push_back(printer_byte_type'{bpr[15:8], 1'b0});
         printer_bytes_due.push_back(printer_byte_type'{h[7:0], 1'b0});
         printer_bytes_due.push_back(printer_byte_type'{h[15:8], 1'b0});
         header_sent = 1'b1;
      end
      // Dark pixels set their dot, leftmost pixel in bit 7.
      if (gray < cfg_threshold) dot_byte[7 - (dot_column % 8)] = 1'b1;
      if (dot_column + 1 >= w) begin
         // Row end, possibly early after a width change; unused low bits stay white.
         dot_row = dot_row + 16'd1;
         closes_image = (dot_row >= h) || (dot_row == 0);
         printer_bytes_due.push_back(printer_byte_type'{dot_byte, closes_image});
         dot_byte = '0;
         dot_column = 0;
         if (closes_image) begin
            dot_row = '0;
            header_sent = 1'b0;
         end
      end else begin
         dot_column++;
         if (dot_column % 8 == 0) begin
            printer_bytes_due.push_back(printer_byte_type'{dot_byte, 1'b0});
            dot_byte = '0;
         end
      end
   endfunction

   function automatic void report_failure(input string msg);
      if (error_count < 10) $display("ERROR: %s", msg);
      error_count++;
   endfunction

   // Driver: offers queued pixels, predicting the output of each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            rasterize_pixel(req_gray_level);
            pixels_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid      <= 1'b1;
               req_gray_level <= pixels_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_trigger) begin
         hold_seen <= hold_trigger;
         hold_left <= LONG_HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Monitor: every byte transaction must match the oldest predicted byte.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (printer_bytes_due.size() == 0) begin
            report_failure($sformatf("unexpected byte %02h is_last=%0b",
                                     rsp_out_byte, rsp_is_last));
         end else begin
            oldest_due = printer_bytes_due.pop_front();
            if (oldest_due.out_byte !== rsp_out_byte || oldest_due.is_last !== rsp_is_last)
               report_failure($sformatf(
                  "byte %0d: expected %02h is_last=%0b, got %02h is_last=%0b",
                  bytes_checked, oldest_due.out_byte, oldest_due.is_last,
                  rsp_out_byte, rsp_is_last));
            bytes_checked++;
            if (rsp_is_last) images_closed++;
         end
      end
   end

   // Stimulus helpers. They are called from the stimulus process, which always
   // resumes right after a rising edge, so the nonblocking writes land cleanly.
   task automatic queue_pixel(input logic [rtbp_pkg::GRAY_W-1:0] gray);
      pixels_to_send.push_back(gray);
      pixels_queued++;
   endtask

   // Leaves the write enable high; the caller lowers it after the last write.
   task automatic write_register(input logic [rtbp_pkg::CSR_IDX_W-1:0]  idx,
                                 input logic [rtbp_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         rtbp_pkg::CSR_IMAGE_WIDTH:    cfg_width     = data[rtbp_pkg::WIDTH_W-1:0];
         rtbp_pkg::CSR_IMAGE_HEIGHT:   cfg_height    = data[rtbp_pkg::HEIGHT_W-1:0];
         rtbp_pkg::CSR_DARK_THRESHOLD: cfg_threshold = data[rtbp_pkg::GRAY_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // Waits until every queued pixel is taken and every predicted byte has come,
   // then lets a partial byte still in the pipeline settle.
   task automatic wait_drained();
      while (pixels_accepted != pixels_queued || printer_bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Each phase takes the next idling pattern: none, sender idle, receiver
   // stalling, then both lightly.
   task automatic begin_phase();
      case (phase_no % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 71; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 71; end
         default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      phase_no++;
   endtask

   // Gray levels: plain noise, values right around the threshold, and the ends.
   function automatic logic [rtbp_pkg::GRAY_W-1:0] pick_gray();
      int pick;
      int near;
      pick = $urandom_range(99);
      if (pick < 45) return rtbp_pkg::GRAY_W'($urandom_range(255));
      if (pick < 75) begin
         near = int'(cfg_threshold) + int'($urandom_range(2)) - 1;
         if (near < 0) near = 0;
         if (near > 255) near = 255;
         return rtbp_pkg::GRAY_W'(near);
      end
      return $urandom_range(1) ? 8'hFF : 8'h00;
   endfunction

   initial begin
      int pick;
      int new_width;
      int new_height;
      int w;
      int h;
      int count;
      int random_pixels;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: the header must show 48 bytes per row and one row.
      // Two pixels leave the image open; narrowing the row to two pixels then
      // makes the next pixel close both the row and the image at once.
      begin_phase();
      queue_pixel(8'h00);
      queue_pixel(8'hFF);
      wait_drained();
      write_register(rtbp_pkg::CSR_IMAGE_WIDTH, 16'd2);
      csr_write_enable <= 1'b0;
      queue_pixel(8'd199);
      wait_drained();

      // Zero width and height act as one; a zero threshold prints nothing.
      // Every pixel is a whole image, so each brings a fresh header.
      begin_phase();
      write_register(rtbp_pkg::CSR_IMAGE_WIDTH, 16'd0);
      write_register(rtbp_pkg::CSR_IMAGE_HEIGHT, 16'd0);
      write_register(rtbp_pkg::CSR_DARK_THRESHOLD, 16'd0);
      csr_write_enable <= 1'b0;
      queue_pixel(8'h00);
      queue_pixel(8'h00);
      wait_drained();

      // An oversized width clamps to the paper width and the tallest height
      // fills both header bytes. After one full byte, the row is cut to ten
      // pixels and the image to one row, so two more pixels end it with padding.
      begin_phase();
      write_register(rtbp_pkg::CSR_IMAGE_WIDTH, 16'h03FF);
      write_register(rtbp_pkg::CSR_IMAGE_HEIGHT, 16'hFFFF);
      write_register(rtbp_pkg::CSR_DARK_THRESHOLD, 16'd255);
      csr_write_enable <= 1'b0;
      queue_pixel(8'h00);
      queue_pixel(8'hFE);
      queue_pixel(8'hFF);
      queue_pixel(8'h80);
      queue_pixel(8'hFF);
      queue_pixel(8'h01);
      queue_pixel(8'hFF);
      queue_pixel(8'h00);
      wait_drained();
      write_register(rtbp_pkg::CSR_IMAGE_WIDTH, 16'd10);
      write_register(rtbp_pkg::CSR_IMAGE_HEIGHT, 16'd1);
      csr_write_enable <= 1'b0;
      queue_pixel(8'hFF);
      queue_pixel(8'hFE);
      wait_drained();

      // Register bits above the field width are dropped and the unmapped index
      // is ignored. Two rows of a three-row image are sent, then the height
      // drops below the rows already done, so the next row ends the image.
      begin_phase();
      write_register(rtbp_pkg::CSR_IMAGE_WIDTH, 16'hFC01);
      write_register(rtbp_pkg::CSR_IMAGE_HEIGHT, 16'd3);
      write_register(rtbp_pkg::CSR_DARK_THRESHOLD, 16'h5A80);
      write_register(CSR_UNMAPPED, 16'hFFFF);
      csr_write_enable <= 1'b0;
      queue_pixel(8'd127);
      queue_pixel(8'd128);
      wait_drained();
      write_register(rtbp_pkg::CSR_IMAGE_HEIGHT, 16'd1);
      csr_write_enable <= 1'b0;
      queue_pixel(8'hFF);
      wait_drained();

      // Back pressure: one-pixel rows make a byte per transaction while the
      // receiver holds off for a long stretch, so the job queue fills and the
      // block stops taking pixels until the receiver lets go.
      phase_no = 0;
      begin_phase();
      write_register(rtbp_pkg::CSR_IMAGE_WIDTH, 16'd1);
      write_register(rtbp_pkg::CSR_IMAGE_HEIGHT, 16'd5);
      write_register(rtbp_pkg::CSR_DARK_THRESHOLD, 16'($urandom_range(255)));
      csr_write_enable <= 1'b0;
      repeat (24) queue_pixel(pick_gray());
      hold_trigger = ~hold_trigger;
      wait_drained();

      // Random phases. Most finish the image in progress; some also send one
      // whole image more, and some stop partway, leaving an open image for the
      // next settings to act on.
      random_pixels = 0;
      while (random_pixels < RANDOM_PIXEL_TARGET) begin
         begin_phase();
         pick = $urandom_range(99);
         if (pick < 65) new_width = $urandom_range(1, 24);
         else if (pick < 85) new_width = $urandom_range(25, 72);
         else if (pick < 92) new_width = 0;
         else new_width = 8 * $urandom_range(1, 2);
         pick = $urandom_range(99);
         if (pick < 8) new_height = 0;
         else if (pick < 60) new_height = 1;
         else new_height = $urandom_range(2, 4);
         w = (new_width == 0) ? 1 : new_width;
         h = (new_height == 0) ? 1 : new_height;
         if (w * h > MAX_IMAGE_PIXELS) new_height = 1;
         write_register(rtbp_pkg::CSR_IMAGE_WIDTH,
                        {6'($urandom_range(63)), rtbp_pkg::WIDTH_W'(new_width)});
         write_register(rtbp_pkg::CSR_IMAGE_HEIGHT, 16'(new_height));
         if ($urandom_range(99) < 70) begin
            pick = $urandom_range(99);
            if (pick < 10)
               write_register(rtbp_pkg::CSR_DARK_THRESHOLD,
                              {8'($urandom_range(255)), 8'd0});
            else if (pick < 20)
               write_register(rtbp_pkg::CSR_DARK_THRESHOLD, 16'd255);
            else
               write_register(rtbp_pkg::CSR_DARK_THRESHOLD,
                              16'($urandom_range(16'hFFFF)));
         end
         csr_write_enable <= 1'b0;

         // Pixels left in the open image under the new settings.
         w = row_pixels();
         h = image_rows();
         count = (dot_column >= w) ? 1 : w - dot_column;
         if (int'(dot_row) + 1 < h) count += (h - int'(dot_row) - 1) * w;

         pick = $urandom_range(99);
         if (pick < 15) count = $urandom_range(1, count);
         else if (pick < 35) count += w * h;
         repeat (count) queue_pixel(pick_gray());
         random_pixels += count;
         wait_drained();
      end

      wait_drained();
      repeat (END_TAIL_CYCLES) @(posedge clock);
      if (printer_bytes_due.size() != 0)
         report_failure($sformatf("%0d predicted bytes never came",
                                  printer_bytes_due.size()));

      $display("Covered %0d pixels in %0d phases with %0d register writes.",
               pixels_accepted, phase_no, csr_writes);
      $display("Checked %0d output bytes over %0d completed images, %0d errors.",
               bytes_checked, images_closed, error_count);
      if (error_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this stimulus.
   initial begin
      #2000000;
      $display("Timeout with %0d of %0d pixels accepted and %0d bytes outstanding.",
               pixels_accepted, pixels_queued, printer_bytes_due.size());
      $display("testbench NOT OK");
      $finish;
   end

endmodule
